### rtl/mqttdf_pkg.sv
// Package with shared types and constants for the MQTT packet deframer.
`default_nettype none

package mqttdf_pkg;

    localparam int MAX_LEN_BYTES_DEF = 4;
    localparam int GROUP_W           = 7;
    localparam int BYTE_W            = 8;
    localparam int NIBBLE_W          = 4;
    localparam int TDATA_W           = 16;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_HALT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [NIBBLE_W-1:0]   packet_type;
        logic [NIBBLE_W-1:0]   header_flags;
        logic [BYTE_W-1:0]     payload_byte;
        logic                  last_of_packet;
    } result_t;

endpackage

`default_nettype wire

### rtl/mqttdf_parser.sv
// Fixed-header parser state machine: one received byte per step, at most one result.
`default_nettype none

module mqttdf_parser
    import mqttdf_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LEN_BYTES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] data_byte,
    output logic                   res_valid,
    output result_t                res
);

    localparam int LEN_W = GROUP_W * MAX_LENGTH_BYTES;
    localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    phase_t               phase_reg, phase_next;
    logic [NIBBLE_W-1:0]  type_reg, type_next;
    logic [NIBBLE_W-1:0]  flags_reg, flags_next;
    logic [LEN_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     seen_reg, seen_next;
    logic [LEN_W-1:0]     left_reg, left_next;

    logic [LEN_W-1:0]     sum_acc;
    logic [CNT_W-1:0]     seen_inc;
    logic                 more_len;
    logic                 len_overflow;
    logic                 last_data;

    assign sum_acc      = sum_reg + (LEN_W'(data_byte[GROUP_W-1:0]) << (seen_reg * GROUP_W));
    assign seen_inc     = seen_reg + CNT_W'(1);
    assign more_len     = data_byte[BYTE_W-1];
    assign len_overflow = more_len && (seen_inc >= CNT_W'(MAX_LENGTH_BYTES));
    assign last_data    = (left_reg <= LEN_W'(1));

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        flags_next = flags_reg;
        sum_next   = sum_reg;
        seen_next  = seen_reg;
        left_next  = left_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    type_next  = data_byte[BYTE_W-1:NIBBLE_W];
                    flags_next = data_byte[NIBBLE_W-1:0];
                    sum_next   = '0;
                    seen_next  = '0;
                    left_next  = '0;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    sum_next  = sum_acc;
                    seen_next = seen_inc;
                    if (more_len)
                    begin
                        if (len_overflow)
                        begin
                            phase_next = PH_HALT;
                        end
                    end
                    else
                    begin
                        seen_next = '0;
                        if (sum_acc == '0)
                        begin
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            left_next  = sum_acc;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (last_data)
                    begin
                        left_next  = '0;
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        left_next = left_reg - LEN_W'(1);
                    end
                end
                PH_HALT:
                begin
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid          = 1'b0;
        res.kind           = KIND_DATA;
        res.packet_type    = type_reg;
        res.header_flags   = flags_reg;
        res.payload_byte   = '0;
        res.last_of_packet = 1'b0;
        unique case (phase_reg)
            PH_LEN:
            begin
                if (len_overflow)
                begin
                    res_valid          = step;
                    res.kind           = KIND_ERROR;
                    res.last_of_packet = 1'b1;
                end
                else if (!more_len && (sum_acc == '0))
                begin
                    res_valid          = step;
                    res.kind           = KIND_EMPTY;
                    res.last_of_packet = 1'b1;
                end
            end
            PH_DATA:
            begin
                res_valid          = step;
                res.kind           = KIND_DATA;
                res.payload_byte   = data_byte;
                res.last_of_packet = last_data;
            end
            PH_TYPE, PH_HALT:
            begin
                res_valid = 1'b0;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            type_reg  <= '0;
            flags_reg <= '0;
            sum_reg   <= '0;
            seen_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            flags_reg <= flags_next;
            sum_reg   <= sum_next;
            seen_reg  <= seen_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mqtt_packet_deframer_top.sv
// Top level of the MQTT packet deframer with input and result registers.
//
// The slave stream carries the received byte stream, one byte per transfer.
// The master stream carries one transfer per payload byte, one per packet with
// a zero remaining length, and one for a malformed remaining length.
// A transfer is accepted on the slave side into an input register; when the
// output register is empty or being taken, the parser updates its state from
// that byte and writes any result into the output register, from which it
// shows on the master side.
// One byte is taken every cycle while results are drained.
// The pace is set by the output register: when the receiver stalls with a
// result held, the input register keeps its byte and tready falls once that
// register is full, so no transfer is lost or repeated.
// After a fourth length byte that still has its continuation bit set the
// block gives one error transfer and then discards all input until reset.
// Reset clears the parser to wait for a type byte and empties both registers.
`default_nettype none

module mqtt_packet_deframer_top
    import mqttdf_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = MAX_LEN_BYTES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [3:0] packet_type, [7:4] header_flags,
                                               // [15:8] payload_byte
    output logic [1:0]              m_tuser,   // [1:0] kind
    output logic                    m_tlast    // last_of_packet
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    logic              stage_go;
    logic              step;
    logic              res_valid;
    result_t           res;

    assign stage_go = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && stage_go;
    assign s_tready = !in_valid_reg || stage_go;

    mqttdf_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (stage_go)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (stage_go && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.payload_byte, out_res_reg.header_flags,
                       out_res_reg.packet_type};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last_of_packet;

endmodule

`default_nettype wire

### rtl/mqttdf_checker.sv
// Port-level assertions for the MQTT packet deframer and their bind.
`default_nettype none

module mqttdf_checker
    import mqttdf_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [BYTE_W-1:0]  s_tdata,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [1:0]         m_tuser,
    input wire logic               m_tlast
);

    logic s_xfer;
    logic m_xfer;

    assign s_xfer = s_tvalid && s_tready && (s_tdata == s_tdata);
    assign m_xfer = m_tvalid && m_tready;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("Stalled result changed before its transfer.");

    a_marks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_DATA) |-> m_tlast && (m_tdata[15:8] == 8'd0))
        else $error("Empty or error result without last mark or with payload.");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_DATA) || (m_tuser == KIND_EMPTY)
            || (m_tuser == KIND_ERROR))
        else $error("Result carries an unused kind code.");

    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && (m_tuser == KIND_ERROR) |=> !m_tvalid)
        else $error("Result given after a length error.");

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        !s_xfer ##1 !s_xfer && !m_tvalid |=> !m_tvalid)
        else $error("Result appeared without an accepted byte.");

endmodule

bind mqtt_packet_deframer_top mqttdf_checker u_mqttdf_checker (.*);

`default_nettype wire
